>>> sv/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the table bit packer
// Field widths, opcodes, register map and the front-to-back job word.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

	// field widths
	localparam int OP_W      = 2;
	localparam int SYMBOL_W  = 8;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int BYTE_W    = 8;
	localparam int PAD_W     = 3;
	localparam int HEADER_W  = 16;
	localparam int TREE_W    = 13;
	localparam int TOTAL_W   = 40;

	// pending byte store, left aligned (one bit short of a byte)
	localparam int PEND_W    = BYTE_W - 1;
	// working word: pending bits plus a whole code
	localparam int WORK_W    = PEND_W + CODE_W + 1;

	// parameter defaults
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;

	// front-to-back queue depth
	localparam int QUEUE_DEPTH  = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_TREE_SIZE = 1'b0;

	// one code table entry
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// work handed from front to back
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} job_t;

endpackage

`default_nettype wire

>>> sv/hbp_cmd_if.sv
// ----------------------------------------------------------------------------
// hbp_cmd_if: command channel
// Valid/ready channel carrying one input word: opcode, symbol and code.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [hbp_pkg::OP_W-1:0]     opcode;
	logic [hbp_pkg::SYMBOL_W-1:0] symbol;
	logic [hbp_pkg::CODE_W-1:0]   code_bits;
	logic [hbp_pkg::LEN_W-1:0]    code_len;

	modport source (output valid, opcode, symbol, code_bits, code_len, input ready);
	modport sink   (input valid, opcode, symbol, code_bits, code_len, output ready);
endinterface

`default_nettype wire

>>> sv/hbp_res_if.sv
// ----------------------------------------------------------------------------
// hbp_res_if: result channel
// Valid/ready channel carrying one packed output byte and flush status.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbp_res_if;
	logic                         valid;
	logic                         ready;
	logic [hbp_pkg::BYTE_W-1:0]   out_byte;
	logic                         byte_present;
	logic [hbp_pkg::PAD_W-1:0]    padding_bits;
	logic [hbp_pkg::HEADER_W-1:0] header_word;
	logic [hbp_pkg::TOTAL_W-1:0]  total_bits;
	logic                         last;

	modport source (output valid, out_byte, byte_present, padding_bits, header_word,
		total_bits, last, input ready);
	modport sink   (input valid, out_byte, byte_present, padding_bits, header_word,
		total_bits, last, output ready);
endinterface

`default_nettype wire

>>> sv/huffman_table_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_packer: prefix code table and bit packer
// Loads a per-symbol code table, packs encoded symbols into bytes, flushes.
//
//   channel  dir  handshake              payload
//   cmd      in   valid/ready            opcode, symbol, code_bits, code_len
//   res      out  valid/ready            out_byte, byte_present, padding_bits,
//                                        header_word, total_bits, last
//   apb      in   psel/penable/pready    tree_size register at address 0
//
// Loads and unused opcodes are consumed in the front and produce nothing.
// An encode that completes bytes is merged into the working word; the packer
// then moves one byte per cycle onto the result register while that is free.
// An encode that completes no byte only merges; a flush gives one result.
// The table read is registered, and a two-word queue lets the front keep
// taking commands while the packer waits on a stalled result channel.
// Reset clears the pending byte, the bit total and tree_size; the table is not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_bit_packer #(
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT,
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	hbp_cmd_if.sink                               cmd,
	hbp_res_if.source                             res,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [hbp_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [hbp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [hbp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);

	logic                       fq_valid;
	logic                       fq_ready;
	hbp_pkg::job_t              fq_job;
	logic                       qb_valid;
	logic                       qb_ready;
	hbp_pkg::job_t              qb_job;
	logic [hbp_pkg::TREE_W-1:0] tree_size_q;
	logic                       sel_tree;

	// register decode: word address bit picks the register
	assign sel_tree = (paddr[2] == hbp_pkg::REG_TREE_SIZE);
	assign pready   = 1'b1;
	assign prdata   = sel_tree ? hbp_pkg::APB_DATA_W'(tree_size_q) : '0;

	// tree_size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_size_q <= '0;
		end else if (psel && penable && pwrite && sel_tree) begin
			tree_size_q <= pwdata[hbp_pkg::TREE_W-1:0];
		end
	end

	hbp_front #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	hbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	hbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.tree_size (tree_size_q),
		.res       (res)
	);

endmodule

`default_nettype wire

>>> sv/hbp_queue.sv
// ----------------------------------------------------------------------------
// hbp_queue: job queue between front and back
// Small register FIFO so the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire hbp_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output hbp_pkg::job_t      pop_job
);

	localparam int DEPTH = hbp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hbp_pkg::job_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/hbp_front.sv
// ----------------------------------------------------------------------------
// hbp_front: command intake and code table
// Accepts commands, writes table loads, looks up encodes and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_front #(
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT,
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hbp_cmd_if.sink       cmd,
	output logic          job_valid,
	input  wire logic     job_ready,
	output hbp_pkg::job_t job
);

	localparam int SYM_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIMIT = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN
		: hbp_pkg::CODE_W;

	hbp_pkg::entry_t             table_mem [SYMBOL_COUNT];
	hbp_pkg::entry_t             rd_entry_s1;
	logic                        valid_s1;
	logic                        flush_s1;
	logic                        accept;
	logic                        in_range;
	logic [SYM_W-1:0]            idx;
	logic                        do_load;
	logic                        do_read;
	logic                        take_flush;
	logic [hbp_pkg::LEN_W-1:0]   sat_len;
	logic [hbp_pkg::CODE_W-1:0]  code_mask;

	assign cmd.ready = !valid_s1 || job_ready;
	assign accept    = cmd.valid && cmd.ready;
	assign in_range  = ({1'b0, cmd.symbol} < (hbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT));
	assign idx       = cmd.symbol[SYM_W-1:0];

	// classify the accepted word
	always_comb begin
		do_load    = 1'b0;
		do_read    = 1'b0;
		take_flush = 1'b0;
		unique case (cmd.opcode)
			hbp_pkg::OP_LOAD:   do_load    = accept && in_range;
			hbp_pkg::OP_ENCODE: do_read    = accept && in_range;
			hbp_pkg::OP_FLUSH:  take_flush = accept;
			default: ;
		endcase
	end

	// clamp length and drop code bits above it
	always_comb begin
		sat_len = (cmd.code_len > hbp_pkg::LEN_W'(LEN_LIMIT)) ? hbp_pkg::LEN_W'(LEN_LIMIT)
			: cmd.code_len;
		for (int i = 0; i < hbp_pkg::CODE_W; i++) begin
			code_mask[i] = (i < int'(sat_len));
		end
	end

	// code table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_load) begin
			table_mem[idx] <= '{code: cmd.code_bits & code_mask, len: sat_len};
		end
		if (do_read) begin
			rd_entry_s1 <= table_mem[idx];
		end
	end

	// lookup stage: hold while the queue is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else if (do_read || take_flush) begin
			valid_s1 <= 1'b1;
			flush_s1 <= take_flush;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign job_valid = valid_s1;
	assign job.flush = flush_s1;
	assign job.code  = flush_s1 ? '0 : rd_entry_s1.code;
	assign job.len   = flush_s1 ? '0 : rd_entry_s1.len;

endmodule

`default_nettype wire

>>> sv/hbp_back.sv
// ----------------------------------------------------------------------------
// hbp_back: bit packer
// Merges codes into the pending byte store and emits bytes and flush results.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	output logic                             job_ready,
	input  wire hbp_pkg::job_t               job,
	input  wire logic [hbp_pkg::TREE_W-1:0]  tree_size,
	hbp_res_if.source                        res
);

	localparam int WORK_W  = hbp_pkg::WORK_W;
	localparam int BYTE_W  = hbp_pkg::BYTE_W;
	localparam int PEND_W  = hbp_pkg::PEND_W;
	localparam int CODE_W  = hbp_pkg::CODE_W;
	localparam int LEN_W   = hbp_pkg::LEN_W;
	localparam int TOTAL_W = hbp_pkg::TOTAL_W;
	localparam int CNT_W   = hbp_pkg::PAD_W;

	logic                busy_q;
	logic [WORK_W-1:0]   work_q;
	logic [LEN_W-1:0]    wn_q;
	logic [PEND_W-1:0]   pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                ov_q;
	logic [BYTE_W-1:0]   obyte_q;
	logic                opresent_q;
	logic [CNT_W-1:0]    opad_q;
	logic [hbp_pkg::HEADER_W-1:0] ohdr_q;
	logic [TOTAL_W-1:0]  ototal_q;
	logic                olast_q;

	logic                out_free;
	logic                pop;
	logic                emit_work;
	logic [CODE_W-1:0]   code_l;
	logic [WORK_W-1:0]   merged;
	logic [LEN_W-1:0]    new_n;
	logic [TOTAL_W:0]    total_sum;
	logic [CNT_W-1:0]    pad;

	assign out_free  = !ov_q || res.ready;
	assign emit_work = busy_q && out_free;
	assign job_ready = !busy_q && (!job.flush || out_free);
	assign pop       = job_valid && job_ready;

	// left-align the code behind the pending bits
	always_comb begin
		code_l    = job.code << (LEN_W'(CODE_W) - job.len);
		merged    = {pend_q, {(WORK_W - PEND_W){1'b0}}}
			| ({code_l, {(WORK_W - CODE_W){1'b0}}} >> cnt_q);
		new_n     = LEN_W'(cnt_q) + job.len;
		total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(job.len);
		pad       = CNT_W'(0) - cnt_q;
	end

	// packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= '0;
			cnt_q   <= '0;
			total_q <= '0;
		end else if (emit_work) begin
			// shift out one byte; leave the remainder as pending bits
			if (wn_q < LEN_W'(2 * BYTE_W)) begin
				busy_q <= 1'b0;
				pend_q <= work_q[WORK_W-BYTE_W-1 -: PEND_W];
				cnt_q  <= CNT_W'(wn_q - LEN_W'(BYTE_W));
			end
		end else if (pop) begin
			if (job.flush) begin
				pend_q  <= '0;
				cnt_q   <= '0;
				total_q <= '0;
			end else begin
				total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				if (new_n < LEN_W'(BYTE_W)) begin
					pend_q <= merged[WORK_W-1 -: PEND_W];
					cnt_q  <= CNT_W'(new_n);
				end else begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	// working word: load on merge, shift on emit
	always_ff @(posedge clk) begin
		if (emit_work) begin
			work_q <= work_q << BYTE_W;
			wn_q   <= wn_q - LEN_W'(BYTE_W);
		end else if (pop && !job.flush) begin
			work_q <= merged;
			wn_q   <= new_n;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_free) begin
			ov_q <= emit_work || (pop && job.flush);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_work) begin
			obyte_q    <= work_q[WORK_W-1 -: BYTE_W];
			opresent_q <= 1'b1;
			opad_q     <= '0;
			ohdr_q     <= '0;
			ototal_q   <= '0;
			olast_q    <= (wn_q < LEN_W'(2 * BYTE_W));
		end else if (pop && job.flush) begin
			obyte_q    <= {pend_q, 1'b0};
			opresent_q <= (cnt_q != '0);
			opad_q     <= pad;
			ohdr_q     <= {pad, tree_size};
			ototal_q   <= total_q;
			olast_q    <= 1'b1;
		end
	end

	assign res.valid        = ov_q;
	assign res.out_byte     = obyte_q;
	assign res.byte_present = opresent_q;
	assign res.padding_bits = opad_q;
	assign res.header_word  = ohdr_q;
	assign res.total_bits   = ototal_q;
	assign res.last         = olast_q;

endmodule

`default_nettype wire

>>> sv/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker: result channel checks
// Watches the top-level result port for handshake and flush consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             res_valid,
	input  wire logic                             res_ready,
	input  wire logic [hbp_pkg::BYTE_W-1:0]       res_out_byte,
	input  wire logic                             res_byte_present,
	input  wire logic [hbp_pkg::PAD_W-1:0]        res_padding_bits,
	input  wire logic [hbp_pkg::HEADER_W-1:0]     res_header_word,
	input  wire logic                             res_last
);

	// hold a stalled word
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_out_byte) && $stable(res_last))
		else $error("result payload changed while stalled");

	// an empty flush carries no byte and no padding, and closes the item
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_byte_present |-> res_last && res_out_byte == '0
			&& res_padding_bits == '0)
		else $error("empty flush result malformed");

	// header top bits carry the padding
	a_header_pad: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_header_word[hbp_pkg::HEADER_W-1 -: hbp_pkg::PAD_W]
			== res_padding_bits)
		else $error("header padding mismatch");

	// padding only follows real pending bits
	a_pad_present: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_padding_bits != '0 |-> res_byte_present && res_last)
		else $error("padding without a byte");

endmodule

bind huffman_table_bit_packer hbp_checker u_hbp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_out_byte     (res.out_byte),
	.res_byte_present (res.byte_present),
	.res_padding_bits (res.padding_bits),
	.res_header_word  (res.header_word),
	.res_last         (res.last)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the table bit packer
// Feeds load, encode, flush and unused-opcode words through the command
// channel under random idling on both sides, predicts every result word from
// its own copy of the code table and packer state, and checks each word on
// the result channel field by field. The tree_size register is rewritten
// between phases and read back.
// ----------------------------------------------------------------------------

module tb;
	localparam int OP_W         = hbp_pkg::OP_W;
	localparam int SYMBOL_W     = hbp_pkg::SYMBOL_W;
	localparam int CODE_W       = hbp_pkg::CODE_W;
	localparam int LEN_W        = hbp_pkg::LEN_W;
	localparam int BYTE_W       = hbp_pkg::BYTE_W;
	localparam int PAD_W        = hbp_pkg::PAD_W;
	localparam int HEADER_W     = hbp_pkg::HEADER_W;
	localparam int TREE_W       = hbp_pkg::TREE_W;
	localparam int TOTAL_W      = hbp_pkg::TOTAL_W;
	localparam int PEND_W       = hbp_pkg::PEND_W;
	localparam int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT;
	localparam int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN;
	localparam int APB_ADDR_W   = hbp_pkg::APB_ADDR_W;
	localparam int APB_DATA_W   = hbp_pkg::APB_DATA_W;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [APB_ADDR_W-1:0] TREE_SIZE_ADDR =
		APB_ADDR_W'(4 * hbp_pkg::REG_TREE_SIZE);
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS = 66;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [SYMBOL_W-1:0] symbol;
		logic [CODE_W-1:0]   code_bits;
		logic [LEN_W-1:0]    code_len;
	} cmd_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                byte_present;
		logic [PAD_W-1:0]    padding_bits;
		logic [HEADER_W-1:0] header_word;
		logic [TOTAL_W-1:0]  total_bits;
		logic                last;
	} res_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	hbp_cmd_if cmd_ch ();
	hbp_res_if res_ch ();

	cmd_word_t cmd_word_q = '0;
	logic      cmd_valid_q = 1'b0;
	logic      sink_ready_q = 1'b0;

	assign cmd_ch.valid     = cmd_valid_q;
	assign cmd_ch.opcode    = cmd_word_q.opcode;
	assign cmd_ch.symbol    = cmd_word_q.symbol;
	assign cmd_ch.code_bits = cmd_word_q.code_bits;
	assign cmd_ch.code_len  = cmd_word_q.code_len;
	assign res_ch.ready     = sink_ready_q;

	huffman_table_bit_packer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// packer state as the testbench sees it
	logic [CODE_W-1:0]  code_of [SYMBOL_COUNT];
	logic [LEN_W-1:0]   len_of [SYMBOL_COUNT];
	logic [PEND_W-1:0]  pend_bits = '0;
	int                 pend_cnt = 0;
	logic [TOTAL_W-1:0] bits_sent = '0;
	logic [TREE_W-1:0]  tree_size_cfg = '0;

	res_word_t words_due[$];
	cmd_word_t cmd_backlog[$];
	int        failures = 0;

	// stimulus bookkeeping: only loaded symbols get encoded
	bit loaded [SYMBOL_COUNT];
	int live_syms[$];

	// idling control, set per phase
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_req = 0;

	int src_gap = 0;
	int sink_gap = 0;
	int hold_left = 0;
	int hold_seen = 0;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// advance the packer state by one accepted command word
	task automatic pack_command(input cmd_word_t w);
		logic [LEN_W-1:0] len;
		logic [63:0]      acc;
		logic [63:0]      shifted;
		logic [PAD_W-1:0] pad;
		int               n;
		res_word_t        r;
		case (w.opcode)
			hbp_pkg::OP_LOAD: begin
				len = (w.code_len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : w.code_len;
				acc = {32'd0, w.code_bits} & ((64'd1 << len) - 64'd1);
				len_of[w.symbol] = len;
				code_of[w.symbol] = acc[CODE_W-1:0];
			end
			hbp_pkg::OP_ENCODE: begin
				len = len_of[w.symbol];
				if (bits_sent > TOTAL_MAX - TOTAL_W'(len))
					bits_sent = TOTAL_MAX;
				else
					bits_sent = bits_sent + TOTAL_W'(len);
				acc = ({57'd0, pend_bits} << len) | {32'd0, code_of[w.symbol]};
				n = pend_cnt + int'(len);
				// emit every completed byte, oldest bit in bit 7
				while (n >= 8) begin
					n -= 8;
					shifted = acc >> n;
					r = '0;
					r.out_byte = shifted[BYTE_W-1:0];
					r.byte_present = 1'b1;
					r.last = (n < 8);
					words_due.push_back(r);
				end
				acc = acc & ((64'd1 << n) - 64'd1);
				pend_bits = acc[PEND_W-1:0];
				pend_cnt = n;
			end
			hbp_pkg::OP_FLUSH: begin
				pad = PAD_W'(8 - pend_cnt);
				r = '0;
				r.byte_present = (pend_cnt != 0);
				if (r.byte_present) begin
					shifted = {57'd0, pend_bits} << pad;
					r.out_byte = shifted[BYTE_W-1:0];
				end
				r.padding_bits = pad;
				r.header_word = {pad, tree_size_cfg};
				r.total_bits = bits_sent;
				r.last = 1'b1;
				words_due.push_back(r);
				pend_bits = '0;
				pend_cnt = 0;
				bits_sent = '0;
			end
			default: begin
				// unused opcode: dropped by the block
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
		input logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_word();
		res_word_t want;
		if (words_due.size() == 0) begin
			$error("result word with none due: out_byte 0x%0h, last %0b",
				res_ch.out_byte, res_ch.last);
			failures++;
		end else begin
			want = words_due.pop_front();
			check_field("out_byte", TOTAL_W'(want.out_byte), TOTAL_W'(res_ch.out_byte));
			check_field("byte_present", TOTAL_W'(want.byte_present),
				TOTAL_W'(res_ch.byte_present));
			check_field("padding_bits", TOTAL_W'(want.padding_bits),
				TOTAL_W'(res_ch.padding_bits));
			check_field("header_word", TOTAL_W'(want.header_word),
				TOTAL_W'(res_ch.header_word));
			check_field("total_bits", want.total_bits, res_ch.total_bits);
			check_field("last", TOTAL_W'(want.last), TOTAL_W'(res_ch.last));
		end
	endtask

	// command driver: predict on acceptance, then offer the next word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			src_gap = 0;
		end else begin
			if (cmd_valid_q && cmd_ch.ready)
				pack_command(cmd_word_q);
			if (!cmd_valid_q || cmd_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					cmd_valid_q <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_word_q <= cmd_backlog.pop_front();
					cmd_valid_q <= 1'b1;
					if (src_idle_on && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 17);
				end else begin
					cmd_valid_q <= 1'b0;
				end
			end
		end
	end

	// result monitor: check accepted words, stall on request or at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready_q <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (res_ch.valid && sink_ready_q)
				check_word();
			if (hold_left > 0) begin
				hold_left--;
				sink_ready_q <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				sink_ready_q <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				sink_ready_q <= 1'b0;
			end else begin
				sink_ready_q <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 17);
			end
		end
	end

	task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
		input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
		cmd_word_t w;
		w.opcode = op;
		w.symbol = sym;
		w.code_bits = bits;
		w.code_len = len;
		cmd_backlog.push_back(w);
		if (op == hbp_pkg::OP_LOAD && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			live_syms.push_back(int'(sym));
		end
	endtask

	// mostly short codes, some long ones, a few zero or over-long lengths
	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r < 3)
			return LEN_W'($urandom_range(33, 63));
		else if (r < 6)
			return LEN_W'($urandom_range(13, 32));
		else
			return LEN_W'($urandom_range(1, 12));
	endfunction

	function automatic logic [SYMBOL_W-1:0] pick_live();
		return SYMBOL_W'(live_syms[$urandom_range(0, live_syms.size() - 1)]);
	endfunction

	// wait until every word is accepted and every result has come
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_valid_q || words_due.size() != 0);
	endtask

	task automatic set_tree_size(input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] got;
		// loads leave nothing to wait for, so give the pipeline time to empty
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TREE_SIZE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tree_size_cfg = value[TREE_W-1:0];
		// read it back
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("tree_size", TOTAL_W'(tree_size_cfg), TOTAL_W'(got));
	endtask

	task automatic random_phase(input int count);
		int r;
		repeat (12)
			queue_cmd(hbp_pkg::OP_LOAD, SYMBOL_W'($urandom_range(0, 255)), $urandom,
				pick_len());
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				queue_cmd(hbp_pkg::OP_ENCODE, pick_live(), $urandom, LEN_W'($urandom));
			else if (r < 85)
				queue_cmd(hbp_pkg::OP_FLUSH, SYMBOL_W'($urandom), $urandom,
					LEN_W'($urandom));
			else if (r < 93)
				queue_cmd(hbp_pkg::OP_LOAD,
					r[0] ? pick_live() : SYMBOL_W'($urandom_range(0, 255)),
					$urandom, pick_len());
			else
				queue_cmd(OP_SPARE, SYMBOL_W'($urandom), $urandom, LEN_W'($urandom));
		end
		queue_cmd(hbp_pkg::OP_FLUSH, '0, '0, '0);
	endtask

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// upper bits of the write are dropped: tree size at its top
		set_tree_size(32'hFFFF_FFFF);

		// flush with nothing encoded, then table edge cases
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		queue_cmd(hbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_LOAD, 8'h80, 32'h8000_0001, 6'd63);
		queue_cmd(hbp_pkg::OP_LOAD, 8'hAA, 32'h0002_AAAA, 6'd33);
		queue_cmd(hbp_pkg::OP_LOAD, 8'h7F, 32'h0000_0005, 6'd3);
		queue_cmd(hbp_pkg::OP_LOAD, 8'h01, 32'h0000_0001, 6'd1);
		queue_cmd(hbp_pkg::OP_LOAD, 8'h55, 32'h0000_00A5, 6'd8);
		queue_cmd(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		// zero-length code, short code, full-width code spilling four bytes
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
		// whole byte then flush: no padding, no partial byte
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h55, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
		// over-long lengths clipped at load
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'hAA, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
		// seven pending bits: one bit of padding
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
		queue_cmd(hbp_pkg::OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);

		// random phases
		set_tree_size(32'h0000_0000);
		random_phase(PHASE_ITEMS);

		// sender without gaps against a long receiver hold
		set_tree_size($urandom);
		src_idle_on = 1'b0;
		random_phase(PHASE_ITEMS);
		@(negedge clk);
		hold_req++;

		set_tree_size(32'h0000_0AAA);
		src_idle_on = 1'b1;
		sink_idle_on = 1'b0;
		random_phase(PHASE_ITEMS);

		// final stretch without idling
		set_tree_size(32'h0000_1FFE);
		src_idle_on = 1'b0;
		random_phase(PHASE_ITEMS);

		wait_drained();
		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && words_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
